>>> design/mfvn_pkg.sv
`default_nettype none

package mfvn_pkg;

   // operation codes of an input item
   localparam logic [1:0] OP_LOAD_VERTEX   = 2'd0;
   localparam logic [1:0] OP_LOAD_TRIANGLE = 2'd1;
   localparam logic [1:0] OP_QUERY         = 2'd2;

   // result kinds
   localparam logic KIND_FACE   = 1'b0;
   localparam logic KIND_VERTEX = 1'b1;

   localparam int MAX_VERTICES_DEF  = 1024;
   localparam int MAX_TRIANGLES_DEF = 2048;

   localparam int COUNT_W = 12;
   localparam logic [15:0] UNIT_ONE = 16'd16384;

   // shared restoring divider: numerator, divisor and quotient widths
   localparam int DIV_NW = 48;
   localparam int DIV_DW = 34;
   localparam int DIV_QW = 16;

   typedef struct packed {
      logic [1:0]         op;
      logic [10:0]        slot;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] pos_z;
      logic [9:0]         corner_a;
      logic [9:0]         corner_b;
      logic [9:0]         corner_c;
   } req_type;

   typedef struct packed {
      logic               kind;
      logic signed [15:0] norm_x;
      logic signed [15:0] norm_y;
      logic signed [15:0] norm_z;
      logic [11:0]        connections;
      logic               degenerate;
   } rsp_type;

endpackage

`default_nettype wire

>>> design/mesh_face_vertex_normals.sv
// Channel   Direction  Handshake                Payload
// req_      in         req_valid / req_ready    req_data  (req_type)
// rsp_      out        rsp_valid / rsp_ready    rsp_data  (rsp_type)
// csr_      in         csr_we                   csr_wdata (triangle count)
//
// Vertex load: written to the store on transfer. Triangle load: result after the one-bit-a-cycle
// normalising shift, a 32-step square root and three divides; a zero cross product goes straight
// to a degenerate result. Vertex query: three divides unless nothing matched, after a walk that
// reads one triangle a cycle, pipelined over two reads.
// Synchronous reset clears control only; the stores hold garbage until written.
// A result waits in the output register while the next item is taken; stall only if it is full.
`default_nettype none

module mesh_face_vertex_normals
   import mfvn_pkg::*;
#(
   parameter int MAX_VERTICES  = MAX_VERTICES_DEF,
   parameter int MAX_TRIANGLES = MAX_TRIANGLES_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire req_type       req_data,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output rsp_type            rsp_data,
   input  wire logic          csr_we,
   input  wire logic [11:0]   csr_wdata
);

   localparam int VA_W   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int TA_W   = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
   localparam int CNT_W  = $clog2(MAX_TRIANGLES + 1);
   localparam int ACC_W  = 16 + CNT_W;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_T_RD   = 4'd1;
   localparam logic [3:0] ST_T_CR   = 4'd2;
   localparam logic [3:0] ST_T_NORM = 4'd3;
   localparam logic [3:0] ST_T_SQ   = 4'd4;
   localparam logic [3:0] ST_T_SQRT = 4'd5;
   localparam logic [3:0] ST_DIV_LD = 4'd6;
   localparam logic [3:0] ST_DIV    = 4'd7;
   localparam logic [3:0] ST_Q_RD   = 4'd8;
   localparam logic [3:0] ST_Q_WALK = 4'd9;
   localparam logic [3:0] ST_Q_END  = 4'd10;
   localparam logic [3:0] ST_FIN    = 4'd11;

   function automatic logic [VA_W-1:0] vaddr(input logic [16:0] x);
      return x[VA_W-1:0];
   endfunction

   function automatic logic vx_oob(input logic [16:0] x);
      return x >= 17'(MAX_VERTICES);
   endfunction

   // registers
   logic [3:0]                state_ff, state_in;
   logic [11:0]               csr_count_ff;
   logic [TA_W-1:0]           slot_ff, slot_in;
   logic                      oob_ff [3];
   logic                      oob_in [3];
   logic signed [33:0]        p_ff [6];
   logic signed [33:0]        p_in [6];
   logic [35:0]               m_ff [3];
   logic [35:0]               m_in [3];
   logic                      neg_ff [3];
   logic                      neg_in [3];
   logic [1:0]                k_ff, k_in;
   logic [63:0]               s_ff, s_in;
   logic [63:0]               root_ff, root_in;
   logic [63:0]               bit_ff, bit_in;
   logic                      div_kind_ff, div_kind_in;
   logic [DIV_DW-1:0]         rem_ff, rem_in;
   logic [DIV_QW-1:0]         low_ff, low_in;
   logic [DIV_DW-1:0]         d_ff, d_in;
   logic [DIV_QW-1:0]         quo_ff, quo_in;
   logic [3:0]                dcnt_ff, dcnt_in;
   logic signed [15:0]        n_ff [3];
   logic signed [15:0]        n_in [3];
   logic [CNT_W-1:0]          t_ff, t_in;
   logic                      s1_ff, s1_in;
   logic                      s2_ff, s2_in;
   logic [47:0]               face2_ff, face2_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic signed [ACC_W-1:0]   acc_ff [3];
   logic signed [ACC_W-1:0]   acc_in [3];
   logic [47:0]               qpos_ff, qpos_in;
   rsp_type                   res_ff, res_in;
   rsp_type                   rsp_data_ff, rsp_data_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // memory ports
   logic [47:0]     vx_rd [3];
   logic [VA_W-1:0] vx_ra [3];
   logic            vx_we;
   logic [29:0]     tri_rd;
   logic            tri_we;
   logic [47:0]     face_rd;
   logic            face_we;
   logic [47:0]     face_wd;

   logic            accept;
   logic [CNT_W-1:0] limit;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign limit     = (32'(csr_count_ff) > MAX_TRIANGLES) ? CNT_W'(MAX_TRIANGLES)
                                                          : CNT_W'(csr_count_ff);

   assign vx_we  = accept && (req_data.op == OP_LOAD_VERTEX) &&
                   !vx_oob(17'(req_data.slot));
   assign tri_we = accept && (req_data.op == OP_LOAD_TRIANGLE) &&
                   (17'(req_data.slot) < 17'(MAX_TRIANGLES));

   always_comb begin
      if (state_ff == ST_IDLE) begin
         vx_ra[0] = (req_data.op == OP_QUERY) ? vaddr(17'(req_data.slot))
                                              : vaddr(17'(req_data.corner_a));
         vx_ra[1] = vaddr(17'(req_data.corner_b));
         vx_ra[2] = vaddr(17'(req_data.corner_c));
      end else begin
         vx_ra[0] = vaddr(17'(tri_rd[29:20]));
         vx_ra[1] = vaddr(17'(tri_rd[19:10]));
         vx_ra[2] = vaddr(17'(tri_rd[9:0]));
      end
   end

   // three copies of the vertex store so that all corners read in the same cycle
   for (genvar g = 0; g < 3; g++) begin : g_vx
      mfvn_ram #(.WIDTH(48), .DEPTH(MAX_VERTICES)) u_vx (
         .clock   (clock),
         .wr_en   (vx_we),
         .wr_addr (vaddr(17'(req_data.slot))),
         .wr_data ({req_data.pos_x, req_data.pos_y, req_data.pos_z}),
         .rd_addr (vx_ra[g]),
         .rd_data (vx_rd[g])
      );
   end

   mfvn_ram #(.WIDTH(30), .DEPTH(MAX_TRIANGLES)) u_tri (
      .clock   (clock),
      .wr_en   (tri_we),
      .wr_addr (TA_W'(req_data.slot)),
      .wr_data ({req_data.corner_a, req_data.corner_b, req_data.corner_c}),
      .rd_addr (t_ff[TA_W-1:0]),
      .rd_data (tri_rd)
   );

   mfvn_ram #(.WIDTH(48), .DEPTH(MAX_TRIANGLES)) u_face (
      .clock   (clock),
      .wr_en   (face_we),
      .wr_addr (slot_ff),
      .wr_data (face_wd),
      .rd_addr (t_ff[TA_W-1:0]),
      .rd_data (face_rd)
   );

   // datapath helpers
   logic signed [15:0] pos [3][3];
   logic signed [16:0] u [3];
   logic signed [16:0] v [3];
   logic signed [34:0] cr [3];
   logic [35:0]        mx;
   logic [61:0]        sq;
   logic [63:0]        root_sum;
   logic [DIV_DW:0]    trial;
   logic               ge;
   logic [DIV_QW-1:0]  quo_next;
   logic [DIV_QW-1:0]  qc;
   logic               sgn;
   logic signed [15:0] nval;
   logic signed [15:0] nfin [3];
   logic [DIV_NW-1:0]  num;
   logic [ACC_W-1:0]   mag;
   logic               match;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         pos[c][0] = oob_ff[c] ? 16'sd0 : vx_rd[c][47:32];
         pos[c][1] = oob_ff[c] ? 16'sd0 : vx_rd[c][31:16];
         pos[c][2] = oob_ff[c] ? 16'sd0 : vx_rd[c][15:0];
      end
      for (int j = 0; j < 3; j++) begin
         u[j] = 17'(pos[0][j]) - 17'(pos[1][j]);
         v[j] = 17'(pos[0][j]) - 17'(pos[2][j]);
      end
      cr[0] = 35'(p_ff[0]) - 35'(p_ff[1]);
      cr[1] = 35'(p_ff[2]) - 35'(p_ff[3]);
      cr[2] = 35'(p_ff[4]) - 35'(p_ff[5]);

      mx = m_ff[0];
      if (m_ff[1] > mx) mx = m_ff[1];
      if (m_ff[2] > mx) mx = m_ff[2];

      sq       = m_ff[k_ff][30:0] * m_ff[k_ff][30:0];
      root_sum = root_ff + bit_ff;

      trial    = {rem_ff, low_ff[DIV_QW-1]};
      ge       = trial >= {1'b0, d_ff};
      quo_next = {quo_ff[DIV_QW-2:0], ge};
      qc       = (quo_next > UNIT_ONE) ? UNIT_ONE : quo_next;
      sgn      = div_kind_ff ? acc_ff[k_ff][ACC_W-1] : neg_ff[k_ff];
      nval     = sgn ? -$signed(qc) : $signed(qc);
      nfin     = n_ff;
      nfin[k_ff] = nval;

      mag = acc_ff[k_ff][ACC_W-1] ? ACC_W'(-acc_ff[k_ff]) : ACC_W'(acc_ff[k_ff]);
      if (div_kind_ff == KIND_FACE) begin
         num = DIV_NW'({m_ff[k_ff][30:0], 14'd0}) + DIV_NW'(root_ff[33:1]);
      end else begin
         num = DIV_NW'({mag, 1'b0}) + DIV_NW'(count_ff);
      end

      match = 1'b0;
      for (int c = 0; c < 3; c++) begin
         if ({pos[c][0], pos[c][1], pos[c][2]} == qpos_ff) match = 1'b1;
      end
   end

   // control and sequencing
   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      oob_in       = oob_ff;
      p_in         = p_ff;
      m_in         = m_ff;
      neg_in       = neg_ff;
      k_in         = k_ff;
      s_in         = s_ff;
      root_in      = root_ff;
      bit_in       = bit_ff;
      div_kind_in  = div_kind_ff;
      rem_in       = rem_ff;
      low_in       = low_ff;
      d_in         = d_ff;
      quo_in       = quo_ff;
      dcnt_in      = dcnt_ff;
      n_in         = n_ff;
      t_in         = t_ff;
      s1_in        = 1'b0;
      s2_in        = 1'b0;
      face2_in     = face2_ff;
      count_in     = count_ff;
      acc_in       = acc_ff;
      qpos_in      = qpos_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      face_we      = 1'b0;
      face_wd      = {nfin[0], nfin[1], nfin[2]};

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.op == OP_LOAD_TRIANGLE && tri_we) begin
                  slot_in   = TA_W'(req_data.slot);
                  oob_in[0] = vx_oob(17'(req_data.corner_a));
                  oob_in[1] = vx_oob(17'(req_data.corner_b));
                  oob_in[2] = vx_oob(17'(req_data.corner_c));
                  state_in  = ST_T_RD;
               end else if (req_data.op == OP_QUERY) begin
                  oob_in[0] = vx_oob(17'(req_data.slot));
                  state_in  = ST_Q_RD;
               end
            end
         end
         ST_T_RD: begin
            p_in[0]  = u[1] * v[2];
            p_in[1]  = u[2] * v[1];
            p_in[2]  = u[2] * v[0];
            p_in[3]  = u[0] * v[2];
            p_in[4]  = u[0] * v[1];
            p_in[5]  = u[1] * v[0];
            state_in = ST_T_CR;
         end
         ST_T_CR: begin
            for (int j = 0; j < 3; j++) begin
               neg_in[j] = cr[j][34];
               m_in[j]   = cr[j][34] ? 36'(-cr[j]) : 36'(cr[j]);
            end
            if (cr[0] == 35'sd0 && cr[1] == 35'sd0 && cr[2] == 35'sd0) begin
               face_we            = 1'b1;
               face_wd            = '0;
               res_in             = '0;
               res_in.kind        = KIND_FACE;
               res_in.degenerate  = 1'b1;
               state_in           = ST_FIN;
            end else begin
               state_in = ST_T_NORM;
            end
         end
         ST_T_NORM: begin
            // bring the largest magnitude into [2^30, 2^31), one bit a cycle
            if (mx[35:31] != '0) begin
               for (int j = 0; j < 3; j++) m_in[j] = m_ff[j] >> 1;
            end else if (!mx[30]) begin
               for (int j = 0; j < 3; j++) m_in[j] = m_ff[j] << 1;
            end else begin
               k_in     = 2'd0;
               s_in     = '0;
               state_in = ST_T_SQ;
            end
         end
         ST_T_SQ: begin
            s_in = s_ff + 64'(sq);
            if (k_ff == 2'd2) begin
               root_in  = '0;
               bit_in   = 64'd1 << 62;
               state_in = ST_T_SQRT;
            end else begin
               k_in = k_ff + 2'd1;
            end
         end
         ST_T_SQRT: begin
            if (s_ff >= root_sum) begin
               s_in    = s_ff - root_sum;
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               div_kind_in = KIND_FACE;
               k_in        = 2'd0;
               state_in    = ST_DIV_LD;
            end
         end
         ST_DIV_LD: begin
            rem_in  = DIV_DW'(num[DIV_NW-1:DIV_QW]);
            low_in  = num[DIV_QW-1:0];
            d_in    = (div_kind_ff == KIND_FACE) ? root_ff[DIV_DW-1:0]
                                                 : DIV_DW'({count_ff, 1'b0});
            quo_in  = '0;
            dcnt_in = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in  = ge ? DIV_DW'(trial - {1'b0, d_ff}) : trial[DIV_DW-1:0];
            low_in  = low_ff << 1;
            quo_in  = quo_next;
            dcnt_in = dcnt_ff + 4'd1;
            if (dcnt_ff == 4'(DIV_QW - 1)) begin
               n_in[k_ff] = nval;
               if (k_ff == 2'd2) begin
                  res_in.kind       = div_kind_ff;
                  res_in.norm_x     = nfin[0];
                  res_in.norm_y     = nfin[1];
                  res_in.norm_z     = nfin[2];
                  res_in.degenerate = 1'b0;
                  if (div_kind_ff == KIND_FACE) begin
                     face_we            = 1'b1;
                     res_in.connections = '0;
                  end else begin
                     res_in.connections = COUNT_W'(count_ff);
                  end
                  state_in = ST_FIN;
               end else begin
                  k_in     = k_ff + 2'd1;
                  state_in = ST_DIV_LD;
               end
            end
         end
         ST_Q_RD: begin
            qpos_in  = oob_ff[0] ? 48'd0 : vx_rd[0];
            t_in     = '0;
            count_in = '0;
            for (int j = 0; j < 3; j++) acc_in[j] = '0;
            state_in = ST_Q_WALK;
         end
         ST_Q_WALK: begin
            // issue: corner and face stores at t
            if (t_ff < limit) begin
               s1_in = 1'b1;
               t_in  = t_ff + CNT_W'(1);
            end
            // stage 1: corners back, fetch their positions
            s2_in     = s1_ff;
            face2_in  = face_rd;
            oob_in[0] = vx_oob(17'(tri_rd[29:20]));
            oob_in[1] = vx_oob(17'(tri_rd[19:10]));
            oob_in[2] = vx_oob(17'(tri_rd[9:0]));
            // stage 2: compare positions, accumulate on a hit
            if (s2_ff && match) begin
               acc_in[0] = acc_ff[0] + ACC_W'($signed(face2_ff[47:32]));
               acc_in[1] = acc_ff[1] + ACC_W'($signed(face2_ff[31:16]));
               acc_in[2] = acc_ff[2] + ACC_W'($signed(face2_ff[15:0]));
               count_in  = count_ff + CNT_W'(1);
            end
            if (t_ff >= limit && !s1_ff && !s2_ff) begin
               state_in = ST_Q_END;
            end
         end
         ST_Q_END: begin
            if (count_ff == '0) begin
               res_in            = '0;
               res_in.kind       = KIND_VERTEX;
               res_in.degenerate = 1'b1;
               state_in          = ST_FIN;
            end else begin
               div_kind_in = KIND_VERTEX;
               k_in        = 2'd0;
               state_in    = ST_DIV_LD;
            end
         end
         ST_FIN: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         csr_count_ff <= '0;
         s1_ff        <= 1'b0;
         s2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         s1_ff        <= s1_in;
         s2_ff        <= s2_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            csr_count_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_ff     <= slot_in;
      oob_ff      <= oob_in;
      p_ff        <= p_in;
      m_ff        <= m_in;
      neg_ff      <= neg_in;
      k_ff        <= k_in;
      s_ff        <= s_in;
      root_ff     <= root_in;
      bit_ff      <= bit_in;
      div_kind_ff <= div_kind_in;
      rem_ff      <= rem_in;
      low_ff      <= low_in;
      d_ff        <= d_in;
      quo_ff      <= quo_in;
      dcnt_ff     <= dcnt_in;
      n_ff        <= n_in;
      t_ff        <= t_in;
      face2_ff    <= face2_in;
      count_ff    <= count_in;
      acc_ff      <= acc_in;
      qpos_ff     <= qpos_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   a_walk_stages: assert property (@(posedge clock) disable iff (reset)
      s2_ff |-> $past(s1_ff))
      else $error("walk compare stage without a preceding fetch");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_Q_WALK) |-> (count_ff <= t_ff))
      else $error("match count ahead of walk index");

   a_sqrt_bit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_T_SQRT) |-> $onehot(bit_ff))
      else $error("square root trial bit lost");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FIN))
      else $error("result presented outside the finish step");
`endif

endmodule

`default_nettype wire

>>> design/mfvn_ram.sv
`default_nettype none

module mfvn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
